/* design/i2cm_pkg.sv */
// i2cm_pkg: word types, command codes and constants for the I2C master bit engine.
// Standalone package; imported by i2c_master_bit_engine_top.
`default_nettype none

package i2cm_pkg;

	// Command codes carried in the mode field
	localparam logic [2:0] MODE_TICK  = 3'd0;
	localparam logic [2:0] MODE_START = 3'd1;
	localparam logic [2:0] MODE_WRITE = 3'd2;
	localparam logic [2:0] MODE_READ  = 3'd3;
	localparam logic [2:0] MODE_STOP  = 3'd4;

	// Status codes
	localparam logic [1:0] STAT_ACK      = 2'd0;
	localparam logic [1:0] STAT_ADDR_NAK = 2'd1;
	localparam logic [1:0] STAT_DATA_NAK = 2'd2;

	// Address byte assembly
	localparam logic [7:0] ADDR_MASK = 8'hfe;
	localparam logic [7:0] DIR_MASK  = 8'h01;

	// Register reset value
	localparam logic [7:0] SLOT_TICKS_RST = 8'd8;

	// Line levels: bit 1 SCL, bit 0 SDA
	localparam logic [1:0] LINES_IDLE = 2'b11;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] data_byte;
		logic       read_dir;
		logic       ack_after_read;
		logic       sda_in;
	} cmd_word_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic [1:0] status;
		logic       done_res;
	} rsp_word_t;

endpackage

`default_nettype wire

/* design/i2c_master_bit_engine_top.sv */
// i2c_master_bit_engine_top: bit-level I2C master, one input word per bus tick.
// Depends on i2cm_pkg for word types, command codes and constants.
`default_nettype none

// Each accepted command word is one tick of the bus engine and produces exactly one
// response word carrying the SCL/SDA drive levels, busy, done, status and the last
// received byte. The engine takes one word every clock cycle while cmd_stall is low; a response word
// is presented once its command word has passed the input register and then the response register,
// and waits there as long as the response side stalls.
// Commands (start plus address, write, read, stop) are taken only while the engine is
// idle and are otherwise ignored. Each waveform slot lasts slot_ticks ticks (zero acts
// as one); write slot_ticks through the cfg port only while the engine is idle.
module i2c_master_bit_engine_top
	import i2cm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire cmd_word_t cmd_word,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_word_t      rsp_word,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic [7:0] cfg_data
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_PREP_LOW, PH_PREP_HIGH, PH_FALL,
		PH_WB_LOW, PH_WB_HIGH, PH_WA_LOW, PH_WA_HIGH,
		PH_RB_LOW, PH_RB_HIGH, PH_RA_LOW, PH_RA_HIGH,
		PH_SP_LOW, PH_SP_HIGH, PH_SP_RISE
	} phase_t;

	// Line levels driven on entry to a phase; idle keeps the current levels
	function automatic logic [1:0] enter_lines(phase_t p, logic [7:0] sb, logic [3:0] bp,
			logic ack, logic [1:0] cur);
		logic bitv;
		logic ackl;
		bitv = sb[3'd7 - bp[2:0]];
		ackl = ~ack;
		unique case (p)
			PH_PREP_LOW:  enter_lines = 2'b01;
			PH_PREP_HIGH: enter_lines = 2'b11;
			PH_FALL:      enter_lines = 2'b10;
			PH_WB_LOW:    enter_lines = {1'b0, bitv};
			PH_WB_HIGH:   enter_lines = {1'b1, bitv};
			PH_WA_LOW:    enter_lines = 2'b01;
			PH_WA_HIGH:   enter_lines = 2'b11;
			PH_RB_LOW:    enter_lines = 2'b01;
			PH_RB_HIGH:   enter_lines = 2'b11;
			PH_RA_LOW:    enter_lines = {1'b0, ackl};
			PH_RA_HIGH:   enter_lines = {1'b1, ackl};
			PH_SP_LOW:    enter_lines = 2'b00;
			PH_SP_HIGH:   enter_lines = 2'b10;
			PH_SP_RISE:   enter_lines = 2'b11;
			default:      enter_lines = cur;
		endcase
	endfunction

	// Input register
	logic      valid_s1;
	cmd_word_t word_s1;
	logic      advance;

	// Engine state
	phase_t     phase_q;
	logic [3:0] bit_q;
	logic [7:0] shift_q;
	logic [7:0] cnt_q;
	logic       addr_q;
	logic       ack_q;
	logic [1:0] lines_q;
	logic [1:0] status_q;
	logic [7:0] rx_q;
	logic [7:0] slot_q;

	// Next state
	phase_t     phase_d;
	logic [3:0] bit_d;
	logic [7:0] shift_d;
	logic [7:0] cnt_d;
	logic       addr_d;
	logic       ack_d;
	logic [1:0] lines_d;
	logic [1:0] status_d;
	logic [7:0] rx_d;
	rsp_word_t  rsp_d;

	logic       busy;
	logic [1:0] lines_shown;
	logic [7:0] ticks;
	logic       rxv;
	logic       done;

	assign advance   = valid_s1 & (~rsp_valid | ~rsp_stall);
	assign cmd_stall = valid_s1 & ~advance;
	assign cfg_ready = 1'b1;
	assign ticks     = (slot_q == 8'd0) ? 8'd1 : slot_q;

	// Compute one bus tick: command launch, then slot timing
	always_comb begin
		phase_d  = phase_q;
		bit_d    = bit_q;
		shift_d  = shift_q;
		cnt_d    = cnt_q;
		addr_d   = addr_q;
		ack_d    = ack_q;
		lines_d  = lines_q;
		status_d = status_q;
		rx_d     = rx_q;
		rxv      = 1'b0;
		done     = 1'b0;

		// Launch a command when idle
		if (phase_q == PH_IDLE) begin
			unique case (word_s1.mode)
				MODE_START: begin
					status_d = STAT_ACK;
					bit_d    = 4'd0;
					shift_d  = (word_s1.data_byte & ADDR_MASK) |
						({7'd0, word_s1.read_dir} & DIR_MASK);
					addr_d   = 1'b1;
					phase_d  = (lines_q == LINES_IDLE) ? PH_FALL : PH_PREP_LOW;
				end
				MODE_WRITE: begin
					status_d = STAT_ACK;
					bit_d    = 4'd0;
					shift_d  = word_s1.data_byte;
					addr_d   = 1'b0;
					phase_d  = PH_WB_LOW;
				end
				MODE_READ: begin
					status_d = STAT_ACK;
					bit_d    = 4'd0;
					ack_d    = word_s1.ack_after_read;
					shift_d  = 8'd0;
					phase_d  = PH_RB_LOW;
				end
				MODE_STOP: begin
					status_d = STAT_ACK;
					bit_d    = 4'd0;
					phase_d  = PH_SP_LOW;
				end
				default: begin
				end
			endcase
			if (phase_d != PH_IDLE) begin
				cnt_d   = 8'd0;
				lines_d = enter_lines(phase_d, shift_d, bit_d, ack_d, lines_q);
			end
		end

		busy        = (phase_d != PH_IDLE);
		lines_shown = lines_d;

		// Advance the slot counter and step the sequence at slot end
		if (busy) begin
			cnt_d = cnt_d + 8'd1;
			if (cnt_d >= ticks) begin
				unique case (phase_d)
					PH_PREP_LOW:  phase_d = PH_PREP_HIGH;
					PH_PREP_HIGH: phase_d = PH_FALL;
					PH_FALL:      phase_d = PH_WB_LOW;
					PH_WB_LOW:    phase_d = PH_WB_HIGH;
					PH_WB_HIGH: begin
						bit_d   = bit_d + 4'd1;
						phase_d = (bit_d >= 4'd8) ? PH_WA_LOW : PH_WB_LOW;
					end
					PH_WA_LOW:    phase_d = PH_WA_HIGH;
					PH_WA_HIGH: begin
						if (word_s1.sda_in) begin
							status_d = addr_d ? STAT_ADDR_NAK : STAT_DATA_NAK;
							phase_d  = PH_SP_LOW;
						end else begin
							done    = 1'b1;
							phase_d = PH_IDLE;
						end
					end
					PH_RB_LOW:    phase_d = PH_RB_HIGH;
					PH_RB_HIGH: begin
						shift_d = {shift_d[6:0], word_s1.sda_in};
						bit_d   = bit_d + 4'd1;
						phase_d = (bit_d >= 4'd8) ? PH_RA_LOW : PH_RB_LOW;
					end
					PH_RA_LOW:    phase_d = PH_RA_HIGH;
					PH_RA_HIGH: begin
						rx_d    = shift_d;
						rxv     = 1'b1;
						done    = 1'b1;
						phase_d = PH_IDLE;
					end
					PH_SP_LOW:    phase_d = PH_SP_HIGH;
					PH_SP_HIGH:   phase_d = PH_SP_RISE;
					default: begin
						done    = 1'b1;
						phase_d = PH_IDLE;
					end
				endcase
				cnt_d   = 8'd0;
				lines_d = enter_lines(phase_d, shift_d, bit_d, ack_d, lines_d);
			end
		end

		rsp_d.scl_out  = lines_shown[1];
		rsp_d.sda_out  = lines_shown[0];
		rsp_d.busy_res = busy;
		rsp_d.rx_byte  = rx_d;
		rsp_d.rx_valid = rxv;
		rsp_d.status   = status_d;
		rsp_d.done_res = done;
	end

	// Capture the incoming word whenever the input side is not stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			word_s1  <= '0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
			word_s1  <= cmd_word;
		end
	end

	// Hold engine state, the slot register and the response word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_q     <= 4'd0;
			shift_q   <= 8'd0;
			cnt_q     <= 8'd0;
			addr_q    <= 1'b0;
			ack_q     <= 1'b0;
			lines_q   <= LINES_IDLE;
			status_q  <= STAT_ACK;
			rx_q      <= 8'd0;
			slot_q    <= SLOT_TICKS_RST;
			rsp_valid <= 1'b0;
			rsp_word  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				slot_q <= cfg_data;
			end
			if (advance) begin
				phase_q  <= phase_d;
				bit_q    <= bit_d;
				shift_q  <= shift_d;
				cnt_q    <= cnt_d;
				addr_q   <= addr_d;
				ack_q    <= ack_d;
				lines_q  <= lines_d;
				status_q <= status_d;
				rx_q     <= rx_d;
				rsp_word <= rsp_d;
			end
			if (advance) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	// A finished command always reports busy on its done tick
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!rsp_word.done_res || rsp_word.busy_res))
		else $error("done without busy");

	// A received byte is only flagged on the last tick of a read
	a_rxv_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!rsp_word.rx_valid || rsp_word.done_res))
		else $error("rx_valid without done");

	// The bit counter never runs past one byte
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= 4'd8)
		else $error("bit position out of range");

	// The status code never takes the unused encoding
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		status_q != 2'd3)
		else $error("bad status code");

endmodule

`default_nettype wire
